// File: hdl/sdfp_pkg.sv
// Shared constants, types and tables for the sky direction to focal plane unit.
package sdfp_pkg;

    localparam int TRIG_FRAC_BITS_DEF = 30;

    localparam int ANGLE_W    = 20;
    localparam int NUM_ANGLES = 5;
    localparam int ANG_MIR_EL = 0;
    localparam int ANG_MIR_AZ = 1;
    localparam int ANG_MIR_RT = 2;
    localparam int ANG_SRC_EL = 3;
    localparam int ANG_SRC_AZ = 4;

    localparam int HORNER_STEPS = 6;
    localparam int TRIG_LAT     = 5 + 2 * HORNER_STEPS + 2;
    localparam int FRAME_LAT    = 4;
    localparam int QUOT_BITS    = 33;
    localparam int PROJ_LAT     = 3 + QUOT_BITS + 1;

    localparam int MDEG_TURN = 360000;
    localparam int MDEG_QUAD = 90000;
    localparam int MDEG_OCT  = 45000;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 19;

    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_ELEVATION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_AZIMUTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_ROTATION  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_RADIUS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_DISTANCE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH_X     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH_Y     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGNITUDE_LIMIT  = 3'd7;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;

    typedef struct packed {
        logic               behind;
        logic signed [31:0] pos;
    } proj_res_t;

    function automatic int sin_den(input int step);
        int r;
        case (step)
            0:       r = 156;
            1:       r = 110;
            2:       r = 72;
            3:       r = 42;
            4:       r = 20;
            default: r = 6;
        endcase
        return r;
    endfunction

    function automatic int cos_den(input int step);
        int r;
        case (step)
            0:       r = 182;
            1:       r = 132;
            2:       r = 90;
            3:       r = 56;
            4:       r = 30;
            default: r = 12;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/sky_direction_to_focal_plane_unit.sv
// Each input transfer passes through the trig, frame and projection pipelines to the output register.
// Throughput: one transfer per cycle; every stage moves together, so the pipeline
// holds only while a result waits on the output and m_tready is low.
// Divider: 33 quotient steps, one per stage; trig: 19 stages, 12 of them Horner steps.
// Reset: synchronous, active low; clears valid bits and loads the register defaults.
module sky_direction_to_focal_plane_unit #(
    parameter int TRIG_FRAC_BITS = sdfp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // source_elevation[17:0], source_azimuth[36:18], brightness[47:37]
    input  logic [sdfp_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // x_position[31:0], y_position[63:32], in_view[64], status[65], zero[71:66]
    output logic [sdfp_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [sdfp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sdfp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import sdfp_pkg::*;

    localparam int F        = TRIG_FRAC_BITS;
    localparam int VW       = F + 4;
    localparam int SIDE_LAT = TRIG_LAT + FRAME_LAT + PROJ_LAT;

    logic signed [17:0] mir_el_reg;
    logic [18:0]        mir_az_reg;
    logic signed [18:0] mir_rot_reg;
    logic [13:0]        radius_reg, cluster_reg;
    logic [15:0]        hwx_reg, hwy_reg;
    logic signed [10:0] mag_lim_reg;

    logic               en;
    logic signed [17:0] src_el;
    logic [18:0]        src_az;
    logic signed [10:0] brightness;
    logic signed [18:0] d_el;
    logic signed [19:0] d_az;
    logic               ok_next;
    logic [SIDE_LAT-1:0] ok_pipe_reg;
    logic signed [14:0] optics_dist;

    logic signed [ANGLE_W-1:0] ang [NUM_ANGLES];
    logic                      trig_valid, frame_valid, px_valid, py_valid;
    logic signed [F+1:0]       sin_v [NUM_ANGLES];
    logic signed [F+1:0]       cos_v [NUM_ANGLES];
    logic signed [VW-1:0]      nx, ny, den;
    proj_res_t                 px_res, py_res;

    logic [32:0] ax, ay;
    logic        view;
    logic        m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mir_el_reg  <= '0;
            mir_az_reg  <= '0;
            mir_rot_reg <= '0;
            radius_reg  <= '0;
            cluster_reg <= '0;
            hwx_reg     <= 16'd15360;
            hwy_reg     <= 16'd15360;
            mag_lim_reg <= 11'sd547;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIRROR_ELEVATION: mir_el_reg  <= cfg_wdata[17:0];
                REG_MIRROR_AZIMUTH:   mir_az_reg  <= cfg_wdata[18:0];
                REG_MIRROR_ROTATION:  mir_rot_reg <= cfg_wdata[18:0];
                REG_MIRROR_RADIUS:    radius_reg  <= cfg_wdata[13:0];
                REG_CLUSTER_DISTANCE: cluster_reg <= cfg_wdata[13:0];
                REG_HALF_WIDTH_X:     hwx_reg     <= cfg_wdata[15:0];
                REG_HALF_WIDTH_Y:     hwy_reg     <= cfg_wdata[15:0];
                REG_MAGNITUDE_LIMIT:  mag_lim_reg <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign src_el     = s_tdata[17:0];
    assign src_az     = s_tdata[36:18];
    assign brightness = s_tdata[47:37];

    assign ang[ANG_MIR_EL] = ANGLE_W'(mir_el_reg);
    assign ang[ANG_MIR_AZ] = signed'({1'b0, mir_az_reg});
    assign ang[ANG_MIR_RT] = ANGLE_W'(mir_rot_reg);
    assign ang[ANG_SRC_EL] = ANGLE_W'(src_el);
    assign ang[ANG_SRC_AZ] = signed'({1'b0, src_az});

    // angular window on raw values, no wrap, plus magnitude limit
    assign d_el    = 19'(mir_el_reg) - 19'(src_el);
    assign d_az    = signed'({1'b0, mir_az_reg}) - signed'({1'b0, src_az});
    assign ok_next = (d_el < 19'sd20000) && (d_el > -19'sd20000) &&
                     (d_az < 20'sd30000) && (d_az > -20'sd30000) &&
                     (brightness <= mag_lim_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_pipe_reg <= {ok_pipe_reg[SIDE_LAT-2:0], ok_next};
        end
    end

    assign optics_dist = signed'({1'b0, radius_reg}) - signed'({1'b0, cluster_reg});

    sdfp_trig #(.F(F)) u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (s_tvalid),
        .i_angle (ang),
        .o_valid (trig_valid),
        .o_sin   (sin_v),
        .o_cos   (cos_v)
    );

    sdfp_frame #(.F(F)) u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (trig_valid),
        .i_sin   (sin_v),
        .i_cos   (cos_v),
        .o_valid (frame_valid),
        .o_nx    (nx),
        .o_ny    (ny),
        .o_den   (den)
    );

    sdfp_proj #(.F(F)) u_proj_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (frame_valid),
        .i_dist  (optics_dist),
        .i_num   (nx),
        .i_den   (den),
        .o_valid (px_valid),
        .o_res   (px_res)
    );

    sdfp_proj #(.F(F)) u_proj_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (frame_valid),
        .i_dist  (optics_dist),
        .i_num   (ny),
        .i_den   (den),
        .o_valid (py_valid),
        .o_res   (py_res)
    );

    assign ax   = px_res.pos[31] ? (33'd0 - 33'(px_res.pos)) : 33'(px_res.pos);
    assign ay   = py_res.pos[31] ? (33'd0 - 33'(py_res.pos)) : 33'(py_res.pos);
    assign view = !px_res.behind && ok_pipe_reg[SIDE_LAT-1] &&
                  (ax < 33'(hwx_reg)) && (ay < 33'(hwy_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= px_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {6'd0, px_res.behind, view, py_res.pos, px_res.pos};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_axes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (px_valid == py_valid) && (!px_valid || (px_res.behind == py_res.behind)))
        else $error("x and y axis pipelines out of step");

    a_behind_not_in_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[65] |-> !m_tdata_reg[64])
        else $error("in_view set on a direction behind the mirror plane");

    a_behind_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[65] |->
        (m_tdata_reg[31:0] == 32'h0 || m_tdata_reg[31:0] == 32'h7FFFFFFF ||
         m_tdata_reg[31:0] == 32'h80000000))
        else $error("x not saturated for a direction behind the mirror plane");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(ok_pipe_reg))
        else $error("pipeline advanced while output stalled");
`endif

endmodule

// File: hdl/sdfp_trig.sv
// Pipelined sine and cosine of several millidegree angles in parallel lanes.
module sdfp_trig #(
    parameter int F = sdfp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 i_valid,
    input  logic signed [sdfp_pkg::ANGLE_W-1:0]  i_angle [sdfp_pkg::NUM_ANGLES],
    output logic                                 o_valid,
    output logic signed [F+1:0]                  o_sin   [sdfp_pkg::NUM_ANGLES],
    output logic signed [F+1:0]                  o_cos   [sdfp_pkg::NUM_ANGLES]
);
    import sdfp_pkg::*;

    localparam int TW = F + 1;
    localparam int S  = F + 9;
    localparam int MW = F + 7;
    localparam int QW = TW + MW;
    localparam int HS = 2 * HORNER_STEPS;
    localparam logic [TW-1:0] ONE   = TW'(1) << F;
    localparam logic [63:0]   K_RAD = PI_Q60 / 64'd180000;
    localparam logic [63:0]   X_RND = 64'd1 << (59 - F);

    function automatic logic [TW-1:0] umulq(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [2*TW-1:0] p;
        p = {TW'(0), a} * {TW'(0), b} + ((2 * TW)'(1) << (F - 1));
        return p[F +: TW];
    endfunction

    logic [TRIG_LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TRIG_LAT-2:0], i_valid};
        end
    end

    assign o_valid = vld_reg[TRIG_LAT-1];

    for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_lane
        logic [18:0]   a_reg, a_next;
        logic [1:0]    q2_reg, q2_next, q3_reg, q4_reg, q5_reg;
        logic [16:0]   r_reg, r_next;
        logic [15:0]   rr_reg;
        logic          sw3_reg, sw4_reg, sw5_reg;
        logic [63:0]   x_prod;
        logic [F-1:0]  x4_reg, x5_reg;
        logic [TW-1:0] x2_reg;
        logic [F-1:0]  hx  [HS];
        logic [TW-1:0] hx2 [HS];
        logic [1:0]    hq  [HS];
        logic          hsw [HS];
        logic [TW-1:0] hs  [HS];
        logic [TW-1:0] hc  [HS];
        logic [TW-1:0] bs_reg, bc_reg, cos_prod;
        logic [1:0]    qf_reg;
        logic          swf_reg;
        logic signed [F+1:0] s0, c0, sin_next, cos_next, sin_reg, cos_reg;

        always_comb begin
            if (i_angle[g] < 0) begin
                a_next = 19'(int'(i_angle[g]) + MDEG_TURN);
            end else if (int'(i_angle[g]) >= MDEG_TURN) begin
                a_next = 19'(int'(i_angle[g]) - MDEG_TURN);
            end else begin
                a_next = 19'(i_angle[g]);
            end
        end

        always_comb begin
            if (a_reg >= 19'(3 * MDEG_QUAD)) begin
                q2_next = 2'd3;
                r_next  = 17'(a_reg - 19'(3 * MDEG_QUAD));
            end else if (a_reg >= 19'(2 * MDEG_QUAD)) begin
                q2_next = 2'd2;
                r_next  = 17'(a_reg - 19'(2 * MDEG_QUAD));
            end else if (a_reg >= 19'(MDEG_QUAD)) begin
                q2_next = 2'd1;
                r_next  = 17'(a_reg - 19'(MDEG_QUAD));
            end else begin
                q2_next = 2'd0;
                r_next  = 17'(a_reg);
            end
        end

        assign x_prod = 64'(rr_reg) * K_RAD + X_RND;

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg   <= a_next;
                q2_reg  <= q2_next;
                r_reg   <= r_next;
                q3_reg  <= q2_reg;
                sw3_reg <= r_reg > 17'(MDEG_OCT);
                rr_reg  <= (r_reg > 17'(MDEG_OCT)) ? 16'(17'(MDEG_QUAD) - r_reg) : 16'(r_reg);
                q4_reg  <= q3_reg;
                sw4_reg <= sw3_reg;
                x4_reg  <= x_prod[60-F +: F];
                q5_reg  <= q4_reg;
                sw5_reg <= sw4_reg;
                x5_reg  <= x4_reg;
                x2_reg  <= umulq(TW'(x4_reg), TW'(x4_reg));
            end
        end

        for (genvar k = 0; k < HS; k++) begin : g_step
            logic [F-1:0]  px;
            logic [TW-1:0] px2, pts, ptc;
            logic [1:0]    pq;
            logic          psw;

            if (k == 0) begin : g_first
                assign px  = x5_reg;
                assign px2 = x2_reg;
                assign pq  = q5_reg;
                assign psw = sw5_reg;
                assign pts = ONE;
                assign ptc = ONE;
            end else begin : g_next
                assign px  = hx[k-1];
                assign px2 = hx2[k-1];
                assign pq  = hq[k-1];
                assign psw = hsw[k-1];
                assign pts = hs[k-1];
                assign ptc = hc[k-1];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    hx[k]  <= px;
                    hx2[k] <= px2;
                    hq[k]  <= pq;
                    hsw[k] <= psw;
                end
            end

            if (k % 2 == 0) begin : g_mul
                always_ff @(posedge aclk) begin
                    if (en) begin
                        hs[k] <= umulq(px2, pts);
                        hc[k] <= umulq(px2, ptc);
                    end
                end
            end else begin : g_div
                // floor division by the series denominator via exact reciprocal
                localparam logic [63:0] DS  = 64'(sin_den(k / 2));
                localparam logic [63:0] DC  = 64'(cos_den(k / 2));
                localparam logic [63:0] MSF = ((64'd1 << S) + DS - 64'd1) / DS;
                localparam logic [63:0] MCF = ((64'd1 << S) + DC - 64'd1) / DC;
                localparam logic [MW-1:0] MS = MW'(MSF);
                localparam logic [MW-1:0] MC = MW'(MCF);
                logic [QW-1:0] prod_s, prod_c;

                assign prod_s = QW'(pts) * QW'(MS);
                assign prod_c = QW'(ptc) * QW'(MC);

                always_ff @(posedge aclk) begin
                    if (en) begin
                        hs[k] <= ONE - TW'(prod_s[QW-1:S]);
                        hc[k] <= ONE - TW'(prod_c[QW-1:S]);
                    end
                end
            end
        end

        assign cos_prod = umulq(hx2[HS-1], hc[HS-1]);

        always_ff @(posedge aclk) begin
            if (en) begin
                bs_reg  <= umulq(TW'(hx[HS-1]), hs[HS-1]);
                bc_reg  <= ONE - (cos_prod >> 1);
                qf_reg  <= hq[HS-1];
                swf_reg <= hsw[HS-1];
            end
        end

        assign s0 = swf_reg ? (F+2)'(bc_reg) : (F+2)'(bs_reg);
        assign c0 = swf_reg ? (F+2)'(bs_reg) : (F+2)'(bc_reg);

        always_comb begin
            case (qf_reg)
                2'd0: begin
                    sin_next = s0;
                    cos_next = c0;
                end
                2'd1: begin
                    sin_next = c0;
                    cos_next = -s0;
                end
                2'd2: begin
                    sin_next = -s0;
                    cos_next = -c0;
                end
                default: begin
                    sin_next = -c0;
                    cos_next = s0;
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sin_reg <= sin_next;
                cos_reg <= cos_next;
            end
        end

        assign o_sin[g] = sin_reg;
        assign o_cos[g] = cos_reg;
    end

endmodule

// File: hdl/sdfp_frame.sv
// Camera basis vectors from the mirror angles and the three dot products.
module sdfp_frame #(
    parameter int F = sdfp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 i_valid,
    input  logic signed [F+1:0]  i_sin [sdfp_pkg::NUM_ANGLES],
    input  logic signed [F+1:0]  i_cos [sdfp_pkg::NUM_ANGLES],
    output logic                 o_valid,
    output logic signed [F+3:0]  o_nx,
    output logic signed [F+3:0]  o_ny,
    output logic signed [F+3:0]  o_den
);
    import sdfp_pkg::*;

    localparam int VW = F + 4;

    function automatic logic signed [VW-1:0] smulq(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic [VW-1:0]   ma, mb, m;
        logic [2*VW-1:0] p;
        ma = a[VW-1] ? VW'(-a) : VW'(a);
        mb = b[VW-1] ? VW'(-b) : VW'(b);
        p  = {VW'(0), ma} * {VW'(0), mb} + ((2 * VW)'(1) << (F - 1));
        m  = p[F +: VW];
        return (a[VW-1] ^ b[VW-1]) ? -m : m;
    endfunction

    logic [FRAME_LAT-1:0] vld_reg;
    logic signed [VW-1:0] se, ce, sa, ca, sr, cr, s_e, c_e, s_a, c_a;

    // stage 1
    logic signed [VW-1:0] zx1_reg, zy1_reg, zz1_reg, p1_reg, p2_reg, xz1_reg, yz1_reg;
    logic signed [VW-1:0] hx1_reg, hy1_reg, hz1_reg, sa1_reg, ca1_reg, sr1_reg, cr1_reg;
    // stage 2
    logic signed [VW-1:0] xx2_reg, xy2_reg, yx2_reg, yy2_reg;
    logic signed [VW-1:0] zx2_reg, zy2_reg, zz2_reg, xz2_reg, yz2_reg;
    logic signed [VW-1:0] hx2_reg, hy2_reg, hz2_reg;
    // stage 3
    logic signed [VW-1:0] nx_a_reg, nx_b_reg, nx_c_reg;
    logic signed [VW-1:0] ny_a_reg, ny_b_reg, ny_c_reg;
    logic signed [VW-1:0] dn_a_reg, dn_b_reg, dn_c_reg;
    // stage 4
    logic signed [VW-1:0] nx_reg, ny_reg, den_reg;

    assign se  = VW'(i_sin[ANG_MIR_EL]);
    assign ce  = VW'(i_cos[ANG_MIR_EL]);
    assign sa  = VW'(i_sin[ANG_MIR_AZ]);
    assign ca  = VW'(i_cos[ANG_MIR_AZ]);
    assign sr  = VW'(i_sin[ANG_MIR_RT]);
    assign cr  = VW'(i_cos[ANG_MIR_RT]);
    assign s_e = VW'(i_sin[ANG_SRC_EL]);
    assign c_e = VW'(i_cos[ANG_SRC_EL]);
    assign s_a = VW'(i_sin[ANG_SRC_AZ]);
    assign c_a = VW'(i_cos[ANG_SRC_AZ]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRAME_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zx1_reg <= smulq(ce, ca);
            zy1_reg <= smulq(ce, sa);
            zz1_reg <= se;
            p1_reg  <= smulq(sr, se);
            p2_reg  <= smulq(cr, se);
            xz1_reg <= smulq(sr, ce);
            yz1_reg <= smulq(cr, ce);
            hx1_reg <= smulq(c_e, c_a);
            hy1_reg <= smulq(c_e, s_a);
            hz1_reg <= s_e;
            sa1_reg <= sa;
            ca1_reg <= ca;
            sr1_reg <= sr;
            cr1_reg <= cr;

            xx2_reg <= smulq(cr1_reg, sa1_reg) - smulq(p1_reg, ca1_reg);
            xy2_reg <= -(smulq(cr1_reg, ca1_reg) + smulq(p1_reg, sa1_reg));
            yx2_reg <= -(smulq(sr1_reg, sa1_reg) + smulq(p2_reg, ca1_reg));
            yy2_reg <= smulq(sr1_reg, ca1_reg) - smulq(p2_reg, sa1_reg);
            zx2_reg <= zx1_reg;
            zy2_reg <= zy1_reg;
            zz2_reg <= zz1_reg;
            xz2_reg <= xz1_reg;
            yz2_reg <= yz1_reg;
            hx2_reg <= hx1_reg;
            hy2_reg <= hy1_reg;
            hz2_reg <= hz1_reg;

            nx_a_reg <= smulq(hx2_reg, xx2_reg);
            nx_b_reg <= smulq(hy2_reg, xy2_reg);
            nx_c_reg <= smulq(hz2_reg, xz2_reg);
            ny_a_reg <= smulq(hx2_reg, yx2_reg);
            ny_b_reg <= smulq(hy2_reg, yy2_reg);
            ny_c_reg <= smulq(hz2_reg, yz2_reg);
            dn_a_reg <= smulq(hx2_reg, zx2_reg);
            dn_b_reg <= smulq(hy2_reg, zy2_reg);
            dn_c_reg <= smulq(hz2_reg, zz2_reg);

            nx_reg  <= nx_a_reg + nx_b_reg + nx_c_reg;
            ny_reg  <= ny_a_reg + ny_b_reg + ny_c_reg;
            den_reg <= dn_a_reg + dn_b_reg + dn_c_reg;
        end
    end

    assign o_valid = vld_reg[FRAME_LAT-1];
    assign o_nx    = nx_reg;
    assign o_ny    = ny_reg;
    assign o_den   = den_reg;

endmodule

// File: hdl/sdfp_proj.sv
// One focal plane axis: scaled ratio by a pipelined restoring divider, rounding, saturation.
module sdfp_proj #(
    parameter int F = sdfp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       i_valid,
    input  logic signed [14:0]         i_dist,
    input  logic signed [F+3:0]        i_num,
    input  logic signed [F+3:0]        i_den,
    output logic                       o_valid,
    output sdfp_pkg::proj_res_t        o_res
);
    import sdfp_pkg::*;

    localparam int VW  = F + 4;
    localparam int DMW = 28;
    localparam int NW  = VW + DMW;
    localparam int DVW = VW + 8;
    localparam int CW  = DVW + QUOT_BITS;

    logic [PROJ_LAT-1:0] vld_reg;

    // stage 0
    logic           behind0_reg, neg0_reg, zero0_reg;
    logic [DMW-1:0] dm0_reg;
    logic [VW-1:0]  nm0_reg;
    logic [DVW-1:0] dv0_reg;
    logic [14:0]    dist_mag;
    // stage 1
    logic           behind1_reg, neg1_reg, zero1_reg;
    logic [NW-1:0]  nmag1_reg;
    logic [DVW-1:0] dv1_reg;
    // stage 2 and divider steps
    logic                 big_reg    [QUOT_BITS+1];
    logic                 behind_reg [QUOT_BITS+1];
    logic                 neg_reg    [QUOT_BITS+1];
    logic                 zero_reg   [QUOT_BITS+1];
    logic [DVW-1:0]       dv_reg     [QUOT_BITS+1];
    logic [DVW-1:0]       rem_reg    [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] q_reg      [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] low_reg    [QUOT_BITS+1];
    // final
    logic [QUOT_BITS:0]   q_round;
    logic                 f_behind, f_neg, f_zero, f_big;
    logic signed [31:0]   pos_next;
    proj_res_t            res_reg;

    assign dist_mag = i_dist[14] ? 15'(-i_dist) : 15'(i_dist);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PROJ_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            behind0_reg <= i_den[VW-1] || (i_den == '0);
            neg0_reg    <= i_dist[14] ^ i_num[VW-1];
            zero0_reg   <= (i_dist == '0) || (i_num == '0);
            dm0_reg     <= DMW'(dist_mag) * DMW'(10240);
            nm0_reg     <= i_num[VW-1] ? VW'(-i_num) : VW'(i_num);
            dv0_reg     <= DVW'(i_den) * DVW'(254);

            behind1_reg <= behind0_reg;
            neg1_reg    <= neg0_reg;
            zero1_reg   <= zero0_reg;
            nmag1_reg   <= NW'(dm0_reg) * NW'(nm0_reg);
            dv1_reg     <= dv0_reg;

            big_reg[0]    <= CW'(nmag1_reg) >= (CW'(dv1_reg) << QUOT_BITS);
            behind_reg[0] <= behind1_reg;
            neg_reg[0]    <= neg1_reg;
            zero_reg[0]   <= zero1_reg;
            dv_reg[0]     <= dv1_reg;
            rem_reg[0]    <= DVW'(nmag1_reg[NW-1:QUOT_BITS]);
            q_reg[0]      <= '0;
            low_reg[0]    <= nmag1_reg[QUOT_BITS-1:0];
        end
    end

    for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_div
        logic [DVW:0] r2;
        logic         take;

        assign r2   = {rem_reg[j-1], low_reg[j-1][QUOT_BITS-j]};
        assign take = r2 >= {1'b0, dv_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]    <= take ? DVW'(r2 - {1'b0, dv_reg[j-1]}) : DVW'(r2);
                q_reg[j]      <= {q_reg[j-1][QUOT_BITS-2:0], take};
                low_reg[j]    <= low_reg[j-1];
                big_reg[j]    <= big_reg[j-1];
                behind_reg[j] <= behind_reg[j-1];
                neg_reg[j]    <= neg_reg[j-1];
                zero_reg[j]   <= zero_reg[j-1];
                dv_reg[j]     <= dv_reg[j-1];
            end
        end
    end

    assign f_behind = behind_reg[QUOT_BITS];
    assign f_neg    = neg_reg[QUOT_BITS];
    assign f_zero   = zero_reg[QUOT_BITS];
    assign f_big    = big_reg[QUOT_BITS];
    assign q_round  = (QUOT_BITS + 1)'(q_reg[QUOT_BITS]) +
                      (QUOT_BITS + 1)'({rem_reg[QUOT_BITS], 1'b0} >= {1'b0, dv_reg[QUOT_BITS]});

    always_comb begin
        if (f_behind) begin
            if (f_zero) begin
                pos_next = '0;
            end else begin
                pos_next = f_neg ? POS_MIN : POS_MAX;
            end
        end else if (f_neg) begin
            if (f_big || q_round > (QUOT_BITS + 1)'(34'h080000000)) begin
                pos_next = POS_MIN;
            end else begin
                pos_next = -signed'(q_round[31:0]);
            end
        end else begin
            if (f_big || q_round > (QUOT_BITS + 1)'(34'h07FFFFFFF)) begin
                pos_next = POS_MAX;
            end else begin
                pos_next = signed'(q_round[31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.behind <= f_behind;
            res_reg.pos    <= pos_next;
        end
    end

    assign o_valid = vld_reg[PROJ_LAT-1];
    assign o_res   = res_reg;

endmodule

// File: test/tb_sky_direction_to_focal_plane_unit.sv
// Testbench for the sky direction to focal plane unit: streaming stimulus and result scoreboard.
class focal_plane_scoreboard;
    typedef struct {
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic        in_view;
        logic        status;
    } spot_t;

    logic signed [17:0] mir_el;
    logic        [18:0] mir_az;
    logic signed [18:0] mir_rot;
    logic        [13:0] radius;
    logic        [13:0] cluster;
    logic        [15:0] half_x;
    logic        [15:0] half_y;
    logic signed [10:0] mag_lim;
    spot_t              pending_spots[$];
    int                 mismatches;

    function new();
        mir_el = '0;
        mir_az = '0;
        mir_rot = '0;
        radius = '0;
        cluster = '0;
        half_x = 16'd15360;
        half_y = 16'd15360;
        mag_lim = 11'sd547;
        mismatches = 0;
    endfunction

    function void write_reg(logic [sdfp_pkg::CFG_INDEX_W-1:0] idx, logic [18:0] v);
        case (idx)
            sdfp_pkg::REG_MIRROR_ELEVATION: mir_el = v[17:0];
            sdfp_pkg::REG_MIRROR_AZIMUTH:   mir_az = v;
            sdfp_pkg::REG_MIRROR_ROTATION:  mir_rot = v;
            sdfp_pkg::REG_MIRROR_RADIUS:    radius = v[13:0];
            sdfp_pkg::REG_CLUSTER_DISTANCE: cluster = v[13:0];
            sdfp_pkg::REG_HALF_WIDTH_X:     half_x = v[15:0];
            sdfp_pkg::REG_HALF_WIDTH_Y:     half_y = v[15:0];
            default:                        mag_lim = v[10:0];
        endcase
    endfunction

    function longint unsigned qmul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 29);
        return p[93:30];
    endfunction

    function longint unsigned mag(longint a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    function longint sqmul(longint a, longint b);
        longint m;
        m = qmul(mag(a), mag(b));
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function void octant_trig(longint unsigned r, output longint s, output longint c);
        longint unsigned sden[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cden[6] = '{182, 132, 90, 56, 30, 12};
        longint unsigned one, k, x, x2, t;
        one = 64'd1 << 30;
        k = sdfp_pkg::PI_Q60 / 64'd180000;
        x = (r * k + (64'd1 << 29)) >> 30;
        x2 = qmul(x, x);
        t = one;
        for (int i = 0; i < 6; i++) t = one - qmul(x2, t) / sden[i];
        s = qmul(x, t);
        t = one;
        for (int i = 0; i < 6; i++) t = one - qmul(x2, t) / cden[i];
        c = one - qmul(x2, t) / 2;
    endfunction

    function void angle_trig(longint mdeg, output longint s, output longint c);
        longint a, q, r, s0, c0;
        a = mdeg % 360000;
        if (a < 0) a += 360000;
        q = a / 90000;
        r = a % 90000;
        if (r > 45000) octant_trig(90000 - r, c0, s0);
        else octant_trig(r, s0, c0);
        case (q)
            0:       begin s = s0;  c = c0;  end
            1:       begin s = c0;  c = -s0; end
            2:       begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0;  end
        endcase
    endfunction

    function longint scale_ratio(longint d, longint num, longint den);
        logic          neg;
        logic [127:0] n, dv, q, rem;
        neg = (d < 0) != (num < 0);
        n = {64'd0, mag(d) * 64'd10240} * {64'd0, mag(num)};
        dv = 128'd254 * den;
        q = n / dv;
        rem = n % dv;
        if (q < (128'd1 << 40) && 2 * rem >= dv) q = q + 1;
        if (neg) begin
            if (q > (128'd1 << 31)) q = 128'd1 << 31;
            return -longint'(q[63:0]);
        end
        if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
        return longint'(q[63:0]);
    endfunction

    function longint behind_pos(longint d, longint num);
        if (d == 0 || num == 0) return 0;
        return ((d < 0) != (num < 0)) ? -64'sd2147483648 : 64'sd2147483647;
    endfunction

    function spot_t project_source(logic [47:0] src);
        logic signed [17:0] src_el_f;
        logic signed [10:0] bright_f;
        longint me, ma, mr, se_in, sa_in, d, x, y, de, da;
        longint se, ce, sa, ca, sr, cr, sE, cE, sA, cA;
        longint zx, zy, zz, xx, xy, xz, yx, yy, yz, hx, hy, hz, nx, ny, den;
        spot_t r;
        src_el_f = src[17:0];
        bright_f = src[47:37];
        me = mir_el;
        ma = longint'(mir_az);
        mr = mir_rot;
        se_in = src_el_f;
        sa_in = longint'(src[36:18]);
        d = longint'(radius) - longint'(cluster);
        angle_trig(me, se, ce);
        angle_trig(ma, sa, ca);
        angle_trig(mr, sr, cr);
        angle_trig(se_in, sE, cE);
        angle_trig(sa_in, sA, cA);
        zx = sqmul(ce, ca);
        zy = sqmul(ce, sa);
        zz = se;
        xx = sqmul(cr, sa) - sqmul(sqmul(sr, se), ca);
        xy = -(sqmul(cr, ca) + sqmul(sqmul(sr, se), sa));
        xz = sqmul(sr, ce);
        yx = -(sqmul(sr, sa) + sqmul(sqmul(cr, se), ca));
        yy = sqmul(sr, ca) - sqmul(sqmul(cr, se), sa);
        yz = sqmul(cr, ce);
        hx = sqmul(cE, cA);
        hy = sqmul(cE, sA);
        hz = sE;
        nx = sqmul(hx, xx) + sqmul(hy, xy) + sqmul(hz, xz);
        ny = sqmul(hx, yx) + sqmul(hy, yy) + sqmul(hz, yz);
        den = sqmul(hx, zx) + sqmul(hy, zy) + sqmul(hz, zz);
        r.status = den <= 0;
        if (r.status) begin
            x = behind_pos(d, nx);
            y = behind_pos(d, ny);
            r.in_view = 1'b0;
        end else begin
            x = scale_ratio(d, nx, den);
            y = scale_ratio(d, ny, den);
            de = me - se_in;
            da = ma - sa_in;
            if (de < 0) de = -de;
            if (da < 0) da = -da;
            r.in_view = de < 20000 && da < 30000 && mag(x) < longint'(half_x)
                        && mag(y) < longint'(half_y) && bright_f <= mag_lim;
        end
        r.x_pos = x[31:0];
        r.y_pos = y[31:0];
        return r;
    endfunction

    function void note_source(logic [47:0] src);
        pending_spots.push_back(project_source(src));
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
    endfunction

    function void check_result(logic [71:0] res);
        spot_t e;
        if (pending_spots.size() == 0) begin
            report("unexpected transfer", 32'd0, res[31:0]);
            return;
        end
        e = pending_spots.pop_front();
        if (res[31:0] !== e.x_pos) report("x_position", e.x_pos, res[31:0]);
        if (res[63:32] !== e.y_pos) report("y_position", e.y_pos, res[63:32]);
        if (res[64] !== e.in_view) report("in_view", 32'(e.in_view), 32'(res[64]));
        if (res[65] !== e.status) report("status", 32'(e.status), 32'(res[65]));
    endfunction
endclass

module tb_sky_direction_to_focal_plane_unit;
    import sdfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    focal_plane_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int recv_hold = 0;
    int cycles = 0;
    int cfg_sets[6][8] = '{
        '{0, 0, 0, 3000, 1000, 15360, 15360, 547},
        '{90000, 359999, 180000, 16383, 0, 65535, 65535, 1000},
        '{-90000, 0, -180000, 0, 16383, 0, 0, -1000},
        '{30000, 120000, 45000, 8000, 2000, 40000, 30000, 300},
        '{-20000, 250000, -90000, 5000, 5000, 20000, 20000, 0},
        '{131072, 524287, 262143, 12000, 500, 50000, 50000, 547}
    };

    sky_direction_to_focal_plane_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    task automatic load_config(int set);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_wdata <= cfg_sets[set][i][18:0];
            sb.write_reg(CFG_INDEX_W'(i), cfg_sets[set][i][18:0]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_source(logic [17:0] el, logic [18:0] az, logic [10:0] br);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {br, az, el};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_source(s_tdata);
    endtask

    task automatic send_random(int set);
        int el, az, br;
        if ($urandom_range(3) == 0) begin
            el = $urandom;
            az = $urandom;
            br = $urandom;
        end else begin
            el = cfg_sets[set][0] + $urandom_range(50000) - 25000;
            az = cfg_sets[set][1] + $urandom_range(70000) - 35000;
            if ($urandom_range(4) == 0) br = $urandom;
            else br = cfg_sets[set][7] + $urandom_range(200) - 100;
        end
        send_source(el[17:0], az[18:0], br[10:0]);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.pending_spots.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int wait_cycles;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_config(0);
        send_idle = 13;
        recv_idle = 84;
        // on axis, edges of the fields, behind the mirror, magnitude at the limit
        send_source(18'd0, 19'd0, 11'd547);
        send_source(18'd0, 19'd0, 11'd548);
        send_source(18'd0, 19'd180000, 11'd0);
        send_source(18'd0, 19'd90000, 11'd0);
        send_source(18'd90000, 19'd0, 11'd0);
        send_source(-18'sd90000, 19'd0, 11'd0);
        send_source(18'd0, 19'd359999, -11'sd1000);
        send_source(18'd19999, 19'd29999, 11'd1000);
        send_source(18'd20000, 19'd30000, 11'd0);
        send_source(-18'sd19999, 19'd5000, 11'd0);
        send_source(18'h1FFFF, 19'h7FFFF, 11'h3FF);
        send_source(18'h20000, 19'd400000, 11'h400);
        send_source(18'h3FFFF, 19'd360000, 11'h7FF);
        send_source(18'd5000, 19'd10000, 11'd100);
        send_source(-18'sd5000, 19'd2000, 11'd100);
        for (int n = 0; n < 60; n++) send_random(0);
        drain();
        for (int set = 1; set < 6; set++) begin
            load_config(set);
            send_idle = set < 3 ? (set == 1 ? 13 : 84) : 0;
            recv_idle = set < 3 ? (set == 1 ? 84 : 13) : 0;
            if (set == 2) begin
                send_idle = 84;
                recv_idle = 13;
            end
            if (set == 4) recv_hold = 400;
            for (int n = 0; n < 78; n++) send_random(set);
            drain();
        end
        wait_cycles = 0;
        while (sb.pending_spots.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (80) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_spots.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
